>>> hw/rtl/modexp_pkg.sv
// Shared constants and sequencer state type for the modular exponentiation block.
package modexp_pkg;

   localparam int OPERAND_WIDTH_DEF = 64;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_MULT,
      ST_SQUARE,
      ST_DONE
   } modexp_state_type;

endpackage

>>> hw/rtl/modular_exponentiation_top.sv
// Top level of the modular exponentiation block: sequencer, operand registers and result register.
// Computes base^exponent mod modulus by right-to-left square-and-multiply. All modular
// products run through one bit-serial multiplier. An item costs one product to reduce the
// base. Then each exponent bit up to the highest set one costs a multiply when the bit is set
// and a squaring when higher bits remain. Zero to the zero gives 1 whatever the modulus;
// otherwise a modulus of 0 or 1 gives 0, and neither case runs a product. A base divisible
// by the modulus gives 0, and otherwise a zero exponent gives 1. Both finish after the
// reducing product. One item is worked on at a time. The next is taken while a finished
// result waits.
module modular_exponentiation_top #(
   parameter int OPERAND_WIDTH = modexp_pkg::OPERAND_WIDTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [OPERAND_WIDTH-1:0] req_base,
   input  logic [OPERAND_WIDTH-1:0] req_exponent,
   input  logic [OPERAND_WIDTH-1:0] req_modulus,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [OPERAND_WIDTH-1:0] rsp_power_residue
);

   import modexp_pkg::*;

   localparam int W = OPERAND_WIDTH;

   modexp_state_type state_ff, state_in;

   logic         launched_ff, launched_in;
   logic [W-1:0] base_ff, base_in;
   logic [W-1:0] exp_ff, exp_in;
   logic [W-1:0] mod_ff, mod_in;
   logic [W-1:0] sq_ff, sq_in;
   logic [W-1:0] acc_ff, acc_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [W-1:0] rsp_power_residue_ff, rsp_power_residue_in;

   logic         req_xfer;
   logic         rsp_free;
   logic         exp_rest_zero;
   logic         mod_trivial;

   logic         mm_start;
   logic [W-1:0] mm_a;
   logic [W-1:0] mm_b;
   logic         mm_done;
   logic [W-1:0] mm_result;

   assign req_xfer      = req_valid && !req_stall;
   assign rsp_free      = !rsp_valid_ff || !rsp_stall;
   assign exp_rest_zero = (exp_ff[W-1:1] == '0);
   assign mod_trivial   = (req_modulus[W-1:1] == '0);

   modexp_mulmod #(
      .W (W)
   ) u_mulmod (
      .clock  (clock),
      .reset  (reset),
      .start  (mm_start),
      .a      (mm_a),
      .b      (mm_b),
      .m      (mod_ff),
      .done   (mm_done),
      .result (mm_result)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (req_base == '0 && req_exponent == '0) begin
                  state_in = ST_DONE;
               end else if (mod_trivial) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_REDUCE;
               end
            end
         end
         ST_REDUCE: begin
            if (mm_done) begin
               if (mm_result == '0 || exp_ff == '0) begin
                  state_in = ST_DONE;
               end else if (exp_ff[0]) begin
                  state_in = ST_MULT;
               end else begin
                  state_in = ST_SQUARE;
               end
            end
         end
         ST_MULT: begin
            if (mm_done) begin
               state_in = exp_rest_zero ? ST_DONE : ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            // the shifted exponent is nonzero here
            if (mm_done) begin
               state_in = exp_ff[1] ? ST_MULT : ST_SQUARE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs to the multiplier and the request channel
   always_comb begin
      req_stall = (state_ff != ST_IDLE);
      mm_start  = 1'b0;
      mm_a      = sq_ff;
      mm_b      = sq_ff;
      case (state_ff)
         ST_REDUCE: begin
            mm_start = !launched_ff;
            mm_a     = W'(1);
            mm_b     = base_ff;
         end
         ST_MULT: begin
            mm_start = !launched_ff;
            mm_a     = acc_ff;
            mm_b     = sq_ff;
         end
         ST_SQUARE: begin
            mm_start = !launched_ff;
         end
         default: begin
            mm_start = 1'b0;
         end
      endcase
   end

   // datapath registers
   always_comb begin
      launched_in          = launched_ff;
      base_in              = base_ff;
      exp_in               = exp_ff;
      mod_in               = mod_ff;
      sq_in                = sq_ff;
      acc_in               = acc_ff;
      rsp_valid_in         = rsp_valid_ff && rsp_stall;
      rsp_power_residue_in = rsp_power_residue_ff;

      if (mm_start) begin
         launched_in = 1'b1;
      end
      if (mm_done) begin
         launched_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               base_in = req_base;
               exp_in  = req_exponent;
               mod_in  = req_modulus;
               if (req_base == '0 && req_exponent == '0) begin
                  acc_in = W'(1);
               end else begin
                  acc_in = '0;
               end
            end
         end
         ST_REDUCE: begin
            if (mm_done) begin
               sq_in  = mm_result;
               acc_in = (mm_result == '0) ? '0 : W'(1);
            end
         end
         ST_MULT: begin
            if (mm_done) begin
               acc_in = mm_result;
            end
         end
         ST_SQUARE: begin
            if (mm_done) begin
               sq_in  = mm_result;
               exp_in = {1'b0, exp_ff[W-1:1]};
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in         = 1'b1;
               rsp_power_residue_in = acc_ff;
            end
         end
         default: begin
            launched_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         launched_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         launched_ff  <= launched_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      base_ff              <= base_in;
      exp_ff               <= exp_in;
      mod_ff               <= mod_in;
      sq_ff                <= sq_in;
      acc_ff               <= acc_in;
      rsp_power_residue_ff <= rsp_power_residue_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_power_residue = rsp_power_residue_ff;

   a_done_in_product_state: assert property (@(posedge clock) disable iff (reset)
      mm_done |-> (state_ff == ST_REDUCE || state_ff == ST_MULT || state_ff == ST_SQUARE))
      else $error("multiplier finished outside a product state");

   a_operands_reduced: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MULT || state_ff == ST_SQUARE) |-> (sq_ff < mod_ff && acc_ff < mod_ff))
      else $error("running operands not reduced below the modulus");

   a_single_launch: assert property (@(posedge clock) disable iff (reset)
      mm_start |=> !mm_start)
      else $error("multiplier launched twice in a row");

   a_launch_idle_unit: assert property (@(posedge clock) disable iff (reset)
      mm_start |-> !launched_ff)
      else $error("multiplier launched while a product is in flight");

endmodule

>>> hw/rtl/modexp_mulmod.sv
// Bit-serial modular multiplier: (a * b) mod m by double-and-add, one bit of b per cycle.
module modexp_mulmod #(
   parameter int W = modexp_pkg::OPERAND_WIDTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] a,
   input  logic [W-1:0] b,
   input  logic [W-1:0] m,
   output logic         done,
   output logic [W-1:0] result
);

   localparam int CW = $clog2(W);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [W-1:0]  acc_ff, acc_in;
   logic [W-1:0]  a_ff, a_in;
   logic [W-1:0]  b_ff, b_in;
   logic [W-1:0]  m_ff, m_in;

   logic [W+1:0]  sum;
   logic [W+1:0]  m1_ext;
   logic [W+1:0]  m2_ext;
   logic [W+1:0]  diff1;
   logic [W+1:0]  diff2;

   // acc and a stay below m, so 2*acc + a stays below 3*m
   always_comb begin
      sum    = {1'b0, acc_ff, 1'b0} + (b_ff[W-1] ? {2'b00, a_ff} : '0);
      m1_ext = {2'b00, m_ff};
      m2_ext = {1'b0, m_ff, 1'b0};
      diff1  = sum - m1_ext;
      diff2  = sum - m2_ext;
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      m_in    = m_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(W - 1);
         acc_in  = '0;
         a_in    = a;
         b_in    = b;
         m_in    = m;
      end else if (busy_ff) begin
         if (sum >= m2_ext) begin
            acc_in = diff2[W-1:0];
         end else if (sum >= m1_ext) begin
            acc_in = diff1[W-1:0];
         end else begin
            acc_in = sum[W-1:0];
         end
         // advance to the next multiplier bit, MSB first
         b_in   = {b_ff[W-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      m_ff   <= m_in;
   end

   assign done   = done_ff;
   assign result = acc_ff;

endmodule
